// ===== design/key_press_classifier_macros.svh =====
// Assertion macros for the key press classifier.
// Included by the RTL files that carry concurrent assertions.
// Assertions are compiled out when ASSERT_OFF is defined.
`ifndef KEY_PRESS_CLASSIFIER_MACROS_SVH
`define KEY_PRESS_CLASSIFIER_MACROS_SVH

`ifndef ASSERT_OFF

`define KPC_ASSERT_CLK(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("key_press_classifier assertion failed");

`define KPC_ASSERT(label, prop) `KPC_ASSERT_CLK(label, clk, rst, prop)

`else

`define KPC_ASSERT_CLK(label, clk_sig, rst_sig, prop)

`define KPC_ASSERT(label, prop)

`endif

`endif

// ===== design/kpc_pkg.sv =====
// Shared types, constants and helper functions for the key press classifier.
// No dependencies; used by the channel interfaces, the core and the top level.
`timescale 1ns / 1ps

package kpc_pkg;

  localparam int unsigned NUM_KEYS = 4;
  localparam int unsigned KEY_W = 2;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned LIMIT_W = 8;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned ORDER_LEN = 3;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE    = 3'd0,
    EV_RELEASE = 3'd1,
    EV_PRESS   = 3'd2,
    EV_LONG    = 3'd3,
    EV_COMBO   = 3'd4
  } kpc_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LONG_PRESS_COUNT = 2'd0,
    REG_COMBO_ENABLE     = 2'd1
  } kpc_reg_t;

  localparam logic [LIMIT_W-1:0] LONG_PRESS_RESET = 8'd250;
  localparam logic COMBO_ENABLE_RESET = 1'b1;

  localparam logic signed [COUNT_W-1:0] PRESS_AT = 9'sd2;
  localparam logic signed [COUNT_W-1:0] LONG_RELOAD = 9'sd3;
  localparam logic signed [COUNT_W-1:0] RELEASE_START = -9'sd2;
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 9'sd255;

  typedef struct packed {
    logic [LIMIT_W-1:0] long_press_count;
    logic               combo_enable;
  } kpc_cfg_t;

  typedef struct packed {
    kpc_kind_t        kind;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] partner;
  } kpc_result_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } kpc_slot_t;

  // Partner search order for each key; an invalid slot ends the list.
  function automatic kpc_slot_t partner_slot(input logic [KEY_W-1:0] key,
                                             input logic [1:0] pos);
    kpc_slot_t slot;
    slot = '{valid: 1'b0, key: 2'd0};
    case (key)
      2'd0: begin
        case (pos)
          2'd0: slot = '{valid: 1'b1, key: 2'd1};
          2'd1: slot = '{valid: 1'b1, key: 2'd2};
          2'd2: slot = '{valid: 1'b1, key: 2'd3};
          default: slot = '{valid: 1'b0, key: 2'd0};
        endcase
      end
      2'd1: begin
        case (pos)
          2'd0: slot = '{valid: 1'b1, key: 2'd0};
          2'd1: slot = '{valid: 1'b1, key: 2'd2};
          default: slot = '{valid: 1'b0, key: 2'd0};
        endcase
      end
      2'd2: begin
        case (pos)
          2'd0: slot = '{valid: 1'b1, key: 2'd0};
          2'd1: slot = '{valid: 1'b1, key: 2'd1};
          2'd2: slot = '{valid: 1'b1, key: 2'd3};
          default: slot = '{valid: 1'b0, key: 2'd0};
        endcase
      end
      default: begin
        case (pos)
          2'd0: slot = '{valid: 1'b1, key: 2'd2};
          2'd1: slot = '{valid: 1'b1, key: 2'd0};
          default: slot = '{valid: 1'b0, key: 2'd0};
        endcase
      end
    endcase
    return slot;
  endfunction

  // First partner in the search order whose key is held (hold count at or above the press count).
  function automatic kpc_slot_t find_partner(input logic [KEY_W-1:0] key,
                                             input logic [NUM_KEYS-1:0] held);
    kpc_slot_t found;
    kpc_slot_t slot;
    found = '{valid: 1'b0, key: 2'd0};
    for (int j = 0; j < ORDER_LEN; j++) begin
      slot = partner_slot(key, 2'(j));
      if (!found.valid && slot.valid && held[slot.key]) begin
        found = slot;
      end
    end
    return found;
  endfunction

endpackage

// ===== design/kpc_key_if.sv =====
// Request channel that carries one tick of key levels.
// Depends on kpc_pkg for the field widths.
`timescale 1ns / 1ps

interface kpc_key_if;
  logic                         valid;
  logic                         ready;
  logic [kpc_pkg::NUM_KEYS-1:0] key_levels;

  modport source (output valid, output key_levels, input ready);
  modport sink (input valid, input key_levels, output ready);
endinterface

// ===== design/kpc_event_if.sv =====
// Request channel that carries one classified key event.
// Depends on kpc_pkg for the field widths.
`timescale 1ns / 1ps

interface kpc_event_if;
  logic                       valid;
  logic                       ready;
  logic [kpc_pkg::KIND_W-1:0] event_kind;
  logic [kpc_pkg::KEY_W-1:0]  event_key;
  logic [kpc_pkg::KEY_W-1:0]  partner_key;

  modport source (output valid, output event_kind, output event_key,
                  output partner_key, input ready);
  modport sink (input valid, input event_kind, input event_key,
                input partner_key, output ready);
endinterface

// ===== design/kpc_core.sv =====
// Scan core: rotating scan index, per-key hold counters and event classification.
// Depends on kpc_pkg and key_press_classifier_macros.svh.
`timescale 1ns / 1ps
`include "key_press_classifier_macros.svh"

module kpc_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [kpc_pkg::NUM_KEYS-1:0] levels,
  input  kpc_pkg::kpc_cfg_t            cfg,
  output kpc_pkg::kpc_result_t         result
);

  logic [kpc_pkg::KEY_W-1:0] scan_index;
  logic signed [kpc_pkg::COUNT_W-1:0] hold_count [kpc_pkg::NUM_KEYS];

  logic signed [kpc_pkg::COUNT_W-1:0] count_cur;
  logic signed [kpc_pkg::COUNT_W-1:0] count_inc;
  logic signed [kpc_pkg::COUNT_W-1:0] count_next;
  logic signed [kpc_pkg::COUNT_W:0]   limit_ext;
  logic [kpc_pkg::NUM_KEYS-1:0]       held;
  kpc_pkg::kpc_slot_t                 partner;

  always_comb begin
    for (int i = 0; i < kpc_pkg::NUM_KEYS; i++) begin
      held[i] = (hold_count[i] >= kpc_pkg::PRESS_AT);
    end
  end

  always_comb begin
    count_cur = hold_count[scan_index];
    count_inc = (count_cur < kpc_pkg::COUNT_MAX) ? count_cur + 9'sd1 : count_cur;
    limit_ext = $signed({2'b00, cfg.long_press_count});
    partner = kpc_pkg::find_partner(scan_index, held);
    count_next = count_cur;
    result.kind = kpc_pkg::EV_NONE;
    result.key = scan_index;
    result.partner = '0;
    if (!levels[scan_index]) begin
      if (count_cur > 9'sd0) begin
        count_next = kpc_pkg::RELEASE_START;
      end else if (count_cur < 9'sd0) begin
        count_next = count_cur + 9'sd1;
        if (count_next == 9'sd0) begin
          result.kind = kpc_pkg::EV_RELEASE;
        end
      end
    end else begin
      count_next = count_inc;
      if (count_inc == kpc_pkg::PRESS_AT) begin
        result.kind = kpc_pkg::EV_PRESS;
        if (cfg.combo_enable && partner.valid) begin
          result.kind = kpc_pkg::EV_COMBO;
          result.partner = partner.key;
        end
      end else if ($signed({count_inc[kpc_pkg::COUNT_W-1], count_inc}) >= limit_ext) begin
        result.kind = kpc_pkg::EV_LONG;
        count_next = kpc_pkg::LONG_RELOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index <= '0;
      for (int i = 0; i < kpc_pkg::NUM_KEYS; i++) begin
        hold_count[i] <= '0;
      end
    end else if (step) begin
      scan_index <= scan_index + 2'd1;
      hold_count[scan_index] <= count_next;
    end
  end

  `KPC_ASSERT(a_scan_advances, step |=> (scan_index == 2'($past(scan_index) + 2'd1)))
  `KPC_ASSERT(a_combo_partner, (result.kind == kpc_pkg::EV_COMBO) |-> (cfg.combo_enable && (result.partner != result.key)))
  `KPC_ASSERT(a_release_key_up, (result.kind == kpc_pkg::EV_RELEASE) |-> !levels[scan_index])

endmodule

// ===== design/key_press_classifier.sv =====
// An accepted request is registered in the input stage, then classified into the result register.
// Throughput: one request per cycle while the output is taken, set by the single-pass classify
// stage and one counter update. The input and result registers stall together when it is not taken.
// Synchronous active-high reset clears the scan index, all hold counters and both
// valid flags, and loads long_press_count = 250 and combo_enable = 1.
`timescale 1ns / 1ps
`include "key_press_classifier_macros.svh"

module key_press_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [kpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kpc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  kpc_key_if.sink                         key_in,
  kpc_event_if.source                     event_out
);

  kpc_pkg::kpc_cfg_t            cfg;
  logic                         s1_valid;
  logic [kpc_pkg::NUM_KEYS-1:0] s1_levels;
  logic                         o_valid;
  kpc_pkg::kpc_result_t         o_result;
  kpc_pkg::kpc_result_t         core_result;
  logic                         advance;
  logic                         step;

  assign advance = !o_valid || event_out.ready;
  assign step = s1_valid && advance;
  assign key_in.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_count <= kpc_pkg::LONG_PRESS_RESET;
      cfg.combo_enable <= kpc_pkg::COMBO_ENABLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kpc_pkg::REG_LONG_PRESS_COUNT: cfg.long_press_count <= cfg_wdata;
        kpc_pkg::REG_COMBO_ENABLE:     cfg.combo_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (key_in.ready) begin
      s1_valid <= key_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key_in.ready) begin
      s1_levels <= key_in.key_levels;
    end
  end

  kpc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .levels (s1_levels),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (step) begin
      o_valid <= 1'b1;
    end else if (event_out.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      o_result <= core_result;
    end
  end

  assign event_out.valid = o_valid;
  assign event_out.event_kind = o_result.kind;
  assign event_out.event_key = o_result.key;
  assign event_out.partner_key = o_result.partner;

  `KPC_ASSERT(a_partner_zero, (o_valid && (o_result.kind != kpc_pkg::EV_COMBO)) |-> (o_result.partner == 2'd0))
  `KPC_ASSERT(a_stage_holds, (s1_valid && !advance) |=> (s1_valid && $stable(s1_levels)))
  `KPC_ASSERT(a_step_fills_output, step |=> o_valid)

endmodule

// ===== bench/key_press_classifier_test.sv =====
// Self-checking testbench for key_press_classifier: key scan ticks go in, classified
// events are checked in order against a predictor of the scan and hold counters.
// Depends on kpc_pkg, kpc_key_if, kpc_event_if and the key_press_classifier RTL.
`timescale 1ns / 1ps

module key_press_classifier_test;

  localparam logic [kpc_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [kpc_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_OFF_CYCLES = 60;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [kpc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [kpc_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  kpc_key_if   key_ch();
  kpc_event_if event_ch();

  key_press_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .key_in    (key_ch),
    .event_out (event_ch)
  );

  logic [kpc_pkg::KEY_W-1:0]          scan_key;
  logic signed [kpc_pkg::COUNT_W-1:0] hold_cnt [kpc_pkg::NUM_KEYS];
  logic [kpc_pkg::LIMIT_W-1:0]        press_limit;
  logic                               combo_on;

  kpc_pkg::kpc_result_t expected_events [$];
  int mismatch_count;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_left;

  logic [kpc_pkg::NUM_KEYS-1:0] held_mask;
  int                           hold_left [kpc_pkg::NUM_KEYS];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int partner_at(input int key, input int pos);
    case (key)
      0: partner_at = (pos == 0) ? 1 : (pos == 1) ? 2 : 3;
      1: partner_at = (pos == 0) ? 0 : (pos == 1) ? 2 : -1;
      2: partner_at = (pos == 0) ? 0 : (pos == 1) ? 1 : 3;
      default: partner_at = (pos == 0) ? 2 : (pos == 1) ? 0 : -1;
    endcase
  endfunction

  function automatic kpc_pkg::kpc_result_t classify_tick(
      input logic [kpc_pkg::NUM_KEYS-1:0] levels);
    kpc_pkg::kpc_result_t ev;
    int key;
    int cnt;
    int other;
    int pos;
    ev.kind = kpc_pkg::EV_NONE;
    ev.key = scan_key;
    ev.partner = '0;
    key = int'(scan_key);
    cnt = int'(hold_cnt[key]);
    if (!levels[key]) begin
      if (cnt > 0) begin
        cnt = kpc_pkg::RELEASE_START;
      end else if (cnt < 0) begin
        cnt++;
        if (cnt == 0) begin
          ev.kind = kpc_pkg::EV_RELEASE;
        end
      end
    end else begin
      if (cnt < kpc_pkg::COUNT_MAX) begin
        cnt++;
      end
      if (cnt == kpc_pkg::PRESS_AT) begin
        ev.kind = kpc_pkg::EV_PRESS;
        if (combo_on) begin
          for (pos = 0; pos < kpc_pkg::ORDER_LEN; pos++) begin
            other = partner_at(key, pos);
            if (other < 0) begin
              break;
            end
            if (hold_cnt[other] >= kpc_pkg::PRESS_AT) begin
              ev.kind = kpc_pkg::EV_COMBO;
              ev.partner = other[kpc_pkg::KEY_W-1:0];
              break;
            end
          end
        end
      end else if (cnt >= int'(press_limit)) begin
        ev.kind = kpc_pkg::EV_LONG;
        cnt = kpc_pkg::LONG_RELOAD;
      end
    end
    hold_cnt[key] = cnt[kpc_pkg::COUNT_W-1:0];
    scan_key = scan_key + 1'b1;
    return ev;
  endfunction

  // Each key alternates between held and released runs of random length, long enough
  // at small limits to reach repeated long presses; some ticks are pure noise.
  function automatic logic [kpc_pkg::NUM_KEYS-1:0] next_levels(input int noise_pct);
    logic [kpc_pkg::NUM_KEYS-1:0] levels;
    int span;
    int noise;
    span = 8 * int'(press_limit) + 12;
    if (span > 160) begin
      span = 160;
    end
    for (int k = 0; k < kpc_pkg::NUM_KEYS; k++) begin
      if (hold_left[k] == 0) begin
        held_mask[k] = ~held_mask[k];
        hold_left[k] = held_mask[k] ? $urandom_range(span, 1) : $urandom_range(16, 1);
      end
      hold_left[k]--;
    end
    levels = held_mask;
    if ($urandom_range(99) < noise_pct) begin
      noise = $urandom_range(15);
      levels = noise[kpc_pkg::NUM_KEYS-1:0];
    end
    return levels;
  endfunction

  task automatic send_levels(input logic [kpc_pkg::NUM_KEYS-1:0] levels);
    while ($urandom_range(99) < send_idle_pct) begin
      key_ch.valid <= 1'b0;
      @(negedge clk);
    end
    key_ch.valid <= 1'b1;
    key_ch.key_levels <= levels;
    @(posedge clk);
    while (!key_ch.ready) begin
      @(posedge clk);
    end
    expected_events.push_back(classify_tick(levels));
    @(negedge clk);
  endtask

  task automatic run_random(input int count, input int noise_pct);
    repeat (count) begin
      send_levels(next_levels(noise_pct));
    end
  endtask

  task automatic drain_events();
    key_ch.valid <= 1'b0;
    while (expected_events.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [kpc_pkg::CFG_INDEX_W-1:0] index,
                           input logic [kpc_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    case (index)
      kpc_pkg::REG_LONG_PRESS_COUNT: press_limit = data;
      kpc_pkg::REG_COMBO_ENABLE: combo_on = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [kpc_pkg::LIMIT_W-1:0] limit, input logic combo);
    logic [kpc_pkg::CFG_DATA_W-1:0] data;
    int unsigned rnd;
    drain_events();
    write_reg(kpc_pkg::REG_LONG_PRESS_COUNT, limit);
    rnd = $urandom;
    data = rnd[kpc_pkg::CFG_DATA_W-1:0];
    data[0] = combo;
    write_reg(kpc_pkg::REG_COMBO_ENABLE, data);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      event_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      event_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    kpc_pkg::kpc_result_t want;
    if (!rst && event_ch.valid && event_ch.ready) begin
      if (expected_events.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT) begin
          $display("unexpected event: kind %0d key %0d partner %0d",
                   event_ch.event_kind, event_ch.event_key, event_ch.partner_key);
        end
        mismatch_count++;
      end else begin
        want = expected_events.pop_front();
        if (event_ch.event_kind !== want.kind || event_ch.event_key !== want.key ||
            event_ch.partner_key !== want.partner) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("event mismatch: expected kind %0d key %0d partner %0d,",
                     want.kind, want.key, want.partner,
                     " got kind %0d key %0d partner %0d",
                     event_ch.event_kind, event_ch.event_key, event_ch.partner_key);
          end
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    run_random(60, 20);
  endtask

  task automatic test_directed_sequence();
    configure(8'd4, 1'b1);
    repeat (12) send_levels('0);
    repeat (16) send_levels('1);
    repeat (12) send_levels('0);
  endtask

  task automatic test_ignored_index();
    configure(8'd10, 1'b1);
    write_reg(REG_SPARE_2, '0);
    write_reg(REG_SPARE_3, '0);
    cfg_we <= 1'b0;
    run_random(40, 10);
  endtask

  task automatic test_small_limits();
    for (int lim = 0; lim < 4; lim++) begin
      configure(lim[kpc_pkg::LIMIT_W-1:0], 1'b1);
      run_random(20, 30);
    end
  endtask

  task automatic test_combo_disabled();
    configure(8'd6, 1'b0);
    run_random(50, 20);
  endtask

  task automatic test_limit_lowered();
    configure(8'd255, 1'b1);
    repeat (24) send_levels('1);
    configure(8'd4, 1'b1);
    repeat (8) send_levels('1);
    run_random(20, 20);
  endtask

  task automatic test_backpressure();
    configure(8'd5, 1'b1);
    stall_left = HOLD_OFF_CYCLES;
    run_random(40, 0);
  endtask

  task automatic test_random_settings();
    int lim;
    repeat (4) begin
      lim = $urandom_range(16, 4);
      configure(lim[kpc_pkg::LIMIT_W-1:0], 1'($urandom_range(1)));
      run_random(40, 20);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    key_ch.valid = 1'b0;
    key_ch.key_levels = '0;
    event_ch.ready = 1'b0;
    scan_key = '0;
    for (int k = 0; k < kpc_pkg::NUM_KEYS; k++) begin
      hold_cnt[k] = '0;
      hold_left[k] = 0;
    end
    held_mask = '0;
    press_limit = kpc_pkg::LONG_PRESS_RESET;
    combo_on = kpc_pkg::COMBO_ENABLE_RESET;
    mismatch_count = 0;
    stall_left = 0;
    send_idle_pct = 18;
    recv_idle_pct = 88;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_sequence();
    test_ignored_index();

    send_idle_pct = 88;
    recv_idle_pct = 18;
    test_small_limits();
    test_combo_disabled();
    test_limit_lowered();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_settings();

    drain_events();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
